// ----- rtl/cpd_pkg.sv -----
// Shared types and constants for the checksummed packet deframer.
`default_nettype none
package cpd_pkg;

   localparam logic [7:0] HEAD_BYTE = 8'hCC;
   localparam logic [7:0] TAIL_BYTE = 8'hB9;
   localparam logic [7:0] CR_BYTE   = 8'h0D;
   localparam logic [7:0] LF_BYTE   = 8'h0A;

   localparam int BYTE_W     = 8;
   localparam int INDEX_W    = 6;
   localparam int CAUSE_W    = 3;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [3:0] {
      PH_HEAD,
      PH_LEN,
      PH_DATA,
      PH_TAIL,
      PH_SUM,
      PH_CR,
      PH_LF,
      PH_SKIP,
      PH_REL
   } phase_type;

   typedef enum logic [CAUSE_W-1:0] {
      CAUSE_NONE     = 3'd0,
      CAUSE_BAD_TAIL = 3'd1,
      CAUSE_BAD_SUM  = 3'd2,
      CAUSE_NO_CR    = 3'd3,
      CAUSE_NO_LF    = 3'd4,
      CAUSE_TOO_LONG = 3'd5
   } cause_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_DROP    = 1'b1
   } kind_type;

endpackage
`default_nettype wire

// ----- rtl/cpd_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module cpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/checksummed_packet_deframer_top.sv -----
// Top level of the checksummed packet deframer: frame parser and payload release.
// Usage:
//   req_* carries received serial bytes, one per transfer (req_tdata = rx_byte).
//   The parser hunts for head 0xCC, takes a length byte and the payload, then
//   checks tail 0xB9, the rotate-and-add checksum, CR and LF.
//   rsp_* carries results: payload bytes of a good frame (rsp_tuser = 0) or a
//   single drop result (rsp_tuser = 1) with its cause; rsp_tlast marks the end
//   of each burst and is always set on a drop result.
// Timing and throughput:
//   A drop result is valid the cycle after the failing byte. After a good
//   LF the parser enters release, the payload RAM read data is registered,
//   and the output register takes the first payload byte; later bytes
//   follow at one byte per cycle while rsp_tready is high. req_tready stays
//   low for the whole burst, read through the single RAM read port.
//   req_tready is also low while a result waits in the output register.
// Reset:
//   Synchronous reset returns the parser to head hunting and empties the
//   output register. The payload RAM is not cleared; a release reads only
//   entries written by the same frame.
// Stall: a pending result holds while rsp_tready is low and blocks input bytes.
`default_nettype none
module checksummed_packet_deframer_top #(
   parameter int MAX_PAYLOAD = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] data_byte, [13:8] byte_index,
                                         // [16:14] error_cause, [23:17] zero
   output logic             rsp_tlast,   // last_flag
   output logic             rsp_tuser    // kind
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   cpd_pkg::phase_type              phase_ff, phase_in;
   logic [cpd_pkg::BYTE_W-1:0]      len_ff, len_in;
   logic [cpd_pkg::BYTE_W-1:0]      sum_ff, sum_in;
   logic [cpd_pkg::BYTE_W-1:0]      count_ff, count_in;
   logic [cpd_pkg::INDEX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                            rd_done_ff, rd_done_in;
   logic                            pend_ff, pend_in;
   logic [cpd_pkg::INDEX_W-1:0]     pend_idx_ff, pend_idx_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_kind_ff, rsp_kind_in;
   logic [cpd_pkg::BYTE_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [cpd_pkg::INDEX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic [cpd_pkg::CAUSE_W-1:0]     rsp_cause_ff, rsp_cause_in;

   logic                            accept;
   logic [cpd_pkg::BYTE_W-1:0]      eff_len;
   logic [cpd_pkg::BYTE_W-1:0]      folded;
   logic                            too_long;
   logic                            slot_free;
   logic                            load;
   logic                            issue;
   logic                            wr_en;
   logic [cpd_pkg::BYTE_W-1:0]      rd_data;

   assign accept    = req_tvalid && req_tready;
   assign eff_len   = (len_ff == 8'd0) ? 8'd1 : len_ff;
   assign folded    = {sum_ff[0], sum_ff[7:1]} + req_tdata;
   assign too_long  = count_ff >= 8'(MAX_PAYLOAD);
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign wr_en     = accept && (phase_ff == cpd_pkg::PH_DATA) && !too_long;

   cpd_ram #(
      .WIDTH (cpd_pkg::BYTE_W),
      .DEPTH (MAX_PAYLOAD)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      phase_in     = phase_ff;
      len_in       = len_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      rd_done_in   = rd_done_ff;
      pend_in      = pend_ff;
      pend_idx_in  = pend_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_cause_in = rsp_cause_ff;
      req_tready   = (phase_ff != cpd_pkg::PH_REL) && !rsp_valid_ff;
      load         = 1'b0;
      issue        = 1'b0;

      case (phase_ff)
         cpd_pkg::PH_REL: begin
            load  = pend_ff && slot_free;
            issue = !rd_done_ff && (!pend_ff || load);
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = cpd_pkg::KIND_PAYLOAD;
               rsp_data_in  = rd_data;
               rsp_index_in = pend_idx_ff;
               rsp_last_in  = (pend_idx_ff == count_ff[cpd_pkg::INDEX_W-1:0]);
               rsp_cause_in = cpd_pkg::CAUSE_NONE;
               pend_in      = 1'b0;
               if (pend_idx_ff == count_ff[cpd_pkg::INDEX_W-1:0]) begin
                  phase_in = cpd_pkg::PH_HEAD;
               end
            end
            if (issue) begin
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff;
               rd_idx_in   = rd_idx_ff + 6'd1;
               rd_done_in  = (rd_idx_ff == count_ff[cpd_pkg::INDEX_W-1:0]);
            end
         end
         default: begin
            if (accept) begin
               rsp_kind_in  = cpd_pkg::KIND_DROP;
               rsp_data_in  = 8'd0;
               rsp_index_in = 6'd0;
               rsp_last_in  = 1'b1;
               case (phase_ff)
                  cpd_pkg::PH_HEAD: begin
                     if (req_tdata == cpd_pkg::HEAD_BYTE) begin
                        phase_in = cpd_pkg::PH_LEN;
                     end
                  end
                  cpd_pkg::PH_LEN: begin
                     len_in   = req_tdata;
                     sum_in   = 8'd0;
                     count_in = 8'd0;
                     phase_in = cpd_pkg::PH_DATA;
                  end
                  cpd_pkg::PH_DATA: begin
                     sum_in = folded;
                     if ({1'b0, count_ff} + 9'd1 < {1'b0, eff_len}) begin
                        count_in = count_ff + 8'd1;
                     end else begin
                        phase_in = cpd_pkg::PH_TAIL;
                     end
                  end
                  cpd_pkg::PH_TAIL: begin
                     if (req_tdata != cpd_pkg::TAIL_BYTE) begin
                        rsp_valid_in = 1'b1;
                        rsp_cause_in = cpd_pkg::CAUSE_BAD_TAIL;
                        phase_in     = cpd_pkg::PH_SKIP;
                     end else begin
                        phase_in = cpd_pkg::PH_SUM;
                     end
                  end
                  cpd_pkg::PH_SUM: begin
                     if (req_tdata != sum_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_cause_in = cpd_pkg::CAUSE_BAD_SUM;
                        phase_in     = cpd_pkg::PH_SKIP;
                     end else begin
                        phase_in = cpd_pkg::PH_CR;
                     end
                  end
                  cpd_pkg::PH_CR: begin
                     if (req_tdata != cpd_pkg::CR_BYTE) begin
                        rsp_valid_in = 1'b1;
                        rsp_cause_in = cpd_pkg::CAUSE_NO_CR;
                        phase_in     = cpd_pkg::PH_SKIP;
                     end else begin
                        phase_in = cpd_pkg::PH_LF;
                     end
                  end
                  cpd_pkg::PH_LF: begin
                     if (req_tdata != cpd_pkg::LF_BYTE) begin
                        rsp_valid_in = 1'b1;
                        rsp_cause_in = cpd_pkg::CAUSE_NO_LF;
                        phase_in     = cpd_pkg::PH_SKIP;
                     end else if (too_long) begin
                        rsp_valid_in = 1'b1;
                        rsp_cause_in = cpd_pkg::CAUSE_TOO_LONG;
                        phase_in     = cpd_pkg::PH_SKIP;
                     end else begin
                        rd_idx_in  = 6'd0;
                        rd_done_in = 1'b0;
                        pend_in    = 1'b0;
                        phase_in   = cpd_pkg::PH_REL;
                     end
                  end
                  default: begin
                     phase_in = cpd_pkg::PH_HEAD;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= cpd_pkg::PH_HEAD;
         len_ff       <= 8'd0;
         sum_ff       <= 8'd0;
         count_ff     <= 8'd0;
         rd_idx_ff    <= 6'd0;
         rd_done_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rd_done_ff   <= rd_done_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff  <= pend_idx_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_cause_ff <= rsp_cause_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_cause_ff, rsp_index_ff, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule
`default_nettype wire

// ----- rtl/cpd_checker.sv -----
// Port-level assertions for the checksummed packet deframer, bound to the top level.
`default_nettype none
module cpd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_drop_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata[13:0] == 14'd0
         && rsp_tdata[16:14] != 3'd0)
      else $error("malformed drop result");

   a_payload_no_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[16:14] == 3'd0)
      else $error("payload result carries a cause");

   a_no_take_while_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(req_tvalid && req_tready))
      else $error("input taken while a result waits");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind checksummed_packet_deframer_top cpd_checker u_cpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
